[hw/rtl/rba_pkg.sv]
// ----------------------------------------------------------------------------
// rba_pkg: shared definitions for the run bitmap allocator
// Default sizes, request and result codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package rba_pkg;

	localparam int unsigned LEAF_BITS_DEF = 32;
	localparam int unsigned MAX_SLOTS_DEF = 4096;

	localparam int unsigned ST_W = 2;
	localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
	localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD     = 2'd2;

	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	typedef struct packed {
		logic            sweep_start;
		logic            load;
		logic            step;
		logic            init_wr;
		logic            free_wr;
		logic            hit_latch;
		logic            alloc_commit;
		logic            free_commit;
		logic            set_res;
		logic [ST_W-1:0] res_code;
		logic            out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic req_bad;
		logic req_long;
		logic func;
		logic ptr_last;
		logic s1_valid;
		logic s1_last;
		logic hit;
		logic out_free;
	} dp_stat_t;

endpackage

[hw/rtl/rba_ram.sv]
// ----------------------------------------------------------------------------
// rba_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rba_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW    = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/rba_ctrl.sv]
// ----------------------------------------------------------------------------
// rba_ctrl: sequencing controller
// Runs the clearing sweep, the first-fit scan, the free sweep and result hand-off.
// ----------------------------------------------------------------------------
module rba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  rba_pkg::dp_stat_t  st,
	output rba_pkg::ctl_cmd_t  cmd
);
	import rba_pkg::*;

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_ALLOC = 3'd3;
	localparam logic [2:0] S_AHIT  = 3'd4;
	localparam logic [2:0] S_FREE  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// A pending configuration write wins over a request word, so the request
	// is held off in that cycle rather than dropped.
	assign in_stall  = (state_q != S_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == S_IDLE) || (state_q == S_INIT);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (st.ptr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load        = 1'b1;
					cmd.sweep_start = 1'b1;
					state_d         = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.req_bad) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_BAD;
					state_d      = S_FIN;
				end else if (st.func == FN_ALLOC && st.req_long) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_NOSPACE;
					state_d      = S_FIN;
				end else begin
					cmd.step = 1'b1;
					state_d  = (st.func == FN_FREE) ? S_FREE : S_ALLOC;
				end
			end
			S_ALLOC: begin
				cmd.step = 1'b1;
				if (st.s1_valid && st.hit) begin
					cmd.hit_latch = 1'b1;
					state_d       = S_AHIT;
				end else if (st.s1_valid && st.s1_last) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_NOSPACE;
					state_d      = S_FIN;
				end
			end
			S_AHIT: begin
				cmd.alloc_commit = 1'b1;
				state_d          = S_FIN;
			end
			S_FREE: begin
				cmd.step    = 1'b1;
				cmd.free_wr = 1'b1;
				if (st.s1_valid && st.s1_last) begin
					cmd.free_commit = 1'b1;
					state_d         = S_FIN;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
		// A new slot count restarts the clearing sweep.
		if (cfg_valid && cfg_ready) begin
			cmd         = '0;
			cmd.sweep_start = 1'b1;
			state_d     = S_INIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_commit |-> $past(cmd.hit_latch))
		else $error("alloc commit without a latched hit");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && !(cfg_valid && cfg_ready)) |=> state_q == S_CHECK)
		else $error("accepted word not checked");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("result loaded over an unsent word");

endmodule

[hw/rtl/rba_dp.sv]
// ----------------------------------------------------------------------------
// rba_dp: allocator datapath
// Leaf word memory, sweep pointer, run fit search, counters and result register.
// ----------------------------------------------------------------------------
module rba_dp #(
	parameter int unsigned LEAF_BITS = rba_pkg::LEAF_BITS_DEF,
	parameter int unsigned MAX_SLOTS = rba_pkg::MAX_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rba_pkg::ctl_cmd_t                 cmd,
	output rba_pkg::dp_stat_t                 st,
	input  logic                              cfg_we,
	input  logic [$clog2(MAX_SLOTS+1)-1:0]    slot_count,
	input  logic                              func,
	input  logic [$clog2(MAX_SLOTS)-1:0]      start_slot,
	input  logic [$clog2(MAX_SLOTS+1)-1:0]    count,
	output logic [$clog2(MAX_SLOTS)-1:0]      slot,
	output logic [rba_pkg::ST_W-1:0]          status,
	output logic [$clog2(MAX_SLOTS+1)-1:0]    free_count,
	output logic                              out_valid,
	input  logic                              out_stall
);
	import rba_pkg::*;

	localparam int unsigned SLOT_W     = $clog2(MAX_SLOTS);
	localparam int unsigned CNT_W      = $clog2(MAX_SLOTS+1);
	localparam int unsigned BW         = CNT_W + 1;
	localparam int unsigned LEAF_COUNT = (MAX_SLOTS + LEAF_BITS - 1) / LEAF_BITS;
	localparam int unsigned AW         = (LEAF_COUNT > 1) ? $clog2(LEAF_COUNT) : 1;
	localparam int unsigned PW         = $clog2(LEAF_COUNT + 1);
	localparam int unsigned OW         = $clog2(LEAF_BITS);
	localparam int unsigned CW         = $clog2(LEAF_BITS + 1);
	localparam int unsigned XW         = ((CNT_W > CW) ? CNT_W : CW) + 1;

	// Request and configuration state
	logic                  func_q;
	logic [SLOT_W-1:0]     start_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      sc_q;
	logic [CNT_W-1:0]      fc_q;

	// Sweep pointer and read stage
	logic [PW-1:0]         ptr_q;
	logic [BW-1:0]         base_q;
	logic                  valid_s1;
	logic [AW-1:0]         addr_s1;
	logic [BW-1:0]         base_s1;

	// Latched hit
	logic [LEAF_BITS-1:0]  word_q;
	logic [OW-1:0]         off_q;
	logic [AW-1:0]         haddr_q;
	logic [BW-1:0]         hbase_q;

	logic [SLOT_W-1:0]     res_slot_q;
	logic [ST_W-1:0]       res_status_q;

	logic                  ptr_end;
	logic [AW-1:0]         ptr_addr;
	logic [BW-1:0]         end_x;
	logic [XW-1:0]         cnt_x;
	logic [LEAF_BITS-1:0]  run;
	logic [LEAF_BITS-1:0]  fit;
	logic [OW-1:0]         off;
	logic [LEAF_BITS-1:0]  init_word;
	logic [LEAF_BITS-1:0]  clr_mask;
	logic [LEAF_BITS-1:0]  rdata;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [LEAF_BITS-1:0]  ram_wdata;
	logic                  ram_re;
	logic [CNT_W-1:0]      cfg_sat;
	logic [CNT_W:0]        fc_sum;
	logic [BW-1:0]         slot_sum;

	assign ptr_end  = (ptr_q >= PW'(LEAF_COUNT));
	assign ptr_addr = ptr_q[AW-1:0];
	assign end_x    = BW'(start_q) + BW'(cnt_q);
	assign cnt_x    = XW'(cnt_q);
	assign run      = {LEAF_BITS{1'b1}} >> (XW'(LEAF_BITS) - cnt_x);
	assign cfg_sat  = (slot_count > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slot_count;
	assign fc_sum   = (CNT_W+1)'(fc_q) + (CNT_W+1)'(cnt_q);
	assign slot_sum = hbase_q + BW'(off_q);

	// One compare per bit position: fit test, clearing pattern and free mask.
	always_comb begin
		for (int j = 0; j < LEAF_BITS; j++) begin
			fit[j] = ((XW'(j) + cnt_x) <= XW'(LEAF_BITS)) && ((rdata & (run << j)) == '0);
			init_word[j] = (base_q + BW'(j)) >= BW'(sc_q);
			clr_mask[j]  = ((base_s1 + BW'(j)) >= BW'(start_q)) && ((base_s1 + BW'(j)) < end_x);
		end
	end

	// Lowest fitting offset.
	always_comb begin
		off = '0;
		for (int j = LEAF_BITS - 1; j >= 0; j--) begin
			if (fit[j]) off = OW'(j);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_addr;
		ram_wdata = init_word;
		if (cmd.init_wr) begin
			ram_we = !ptr_end;
		end else if (cmd.free_wr && valid_s1) begin
			ram_we    = 1'b1;
			ram_waddr = addr_s1;
			ram_wdata = rdata & ~clr_mask;
		end else if (cmd.alloc_commit) begin
			ram_we    = 1'b1;
			ram_waddr = haddr_q;
			ram_wdata = word_q | (run << off_q);
		end
	end

	assign ram_re = cmd.step && !ptr_end;

	rba_ram #(
		.WIDTH (LEAF_BITS),
		.DEPTH (LEAF_COUNT),
		.AW    (AW)
	) u_leaf_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ptr_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			base_q    <= '0;
			valid_s1  <= 1'b0;
			sc_q      <= CNT_W'(MAX_SLOTS);
			fc_q      <= CNT_W'(MAX_SLOTS);
			out_valid <= 1'b0;
		end else begin
			if (cmd.sweep_start) begin
				ptr_q  <= '0;
				base_q <= '0;
			end else if ((cmd.step || cmd.init_wr) && !ptr_end) begin
				ptr_q  <= ptr_q + PW'(1);
				base_q <= base_q + BW'(LEAF_BITS);
			end
			valid_s1 <= ram_re;
			if (cfg_we) begin
				sc_q <= cfg_sat;
				fc_q <= cfg_sat;
			end else if (cmd.alloc_commit) begin
				fc_q <= (fc_q >= cnt_q) ? (fc_q - cnt_q) : '0;
			end else if (cmd.free_commit) begin
				fc_q <= (fc_sum > (CNT_W+1)'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : fc_sum[CNT_W-1:0];
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			addr_s1 <= ptr_addr;
			base_s1 <= base_q;
		end
		if (cmd.load) begin
			func_q  <= func;
			start_q <= start_slot;
			cnt_q   <= count;
		end
		if (cmd.hit_latch) begin
			word_q  <= rdata;
			off_q   <= off;
			haddr_q <= addr_s1;
			hbase_q <= base_s1;
		end
		if (cmd.set_res) begin
			res_slot_q   <= '0;
			res_status_q <= cmd.res_code;
		end else if (cmd.alloc_commit) begin
			res_slot_q   <= slot_sum[SLOT_W-1:0];
			res_status_q <= ST_DONE;
		end else if (cmd.free_commit) begin
			res_slot_q   <= '0;
			res_status_q <= ST_DONE;
		end
		if (cmd.out_load) begin
			slot       <= res_slot_q;
			status     <= res_status_q;
			free_count <= fc_q;
		end
	end

	assign st.req_bad  = (cnt_q == '0) || (func_q == FN_FREE && end_x > BW'(sc_q));
	assign st.req_long = (cnt_q > CNT_W'(LEAF_BITS));
	assign st.func     = func_q;
	assign st.ptr_last = (ptr_q == PW'(LEAF_COUNT - 1));
	assign st.s1_valid = valid_s1;
	assign st.s1_last  = (addr_s1 == AW'(LEAF_COUNT - 1));
	assign st.hit      = |fit;
	assign st.out_free = !out_valid || !out_stall;

	assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= CNT_W'(MAX_SLOTS))
		else $error("free counter above slot capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_commit |-> ((XW'(off_q) + cnt_x) <= XW'(LEAF_BITS)))
		else $error("allocated run leaves its leaf word");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (addr_s1 <= AW'(LEAF_COUNT - 1)))
		else $error("read stage beyond last leaf word");

endmodule

[hw/rtl/run_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// run_bitmap_allocator: first-fit allocator for runs of slots
// Slot bitmap kept as leaf words in RAM, scanned one word per cycle.
// ----------------------------------------------------------------------------
// Requests arrive on the in channel (in_valid/in_stall) with func, start_slot
// and count; one result word (slot, status, free_count) leaves on the out
// channel (out_valid/out_stall) per request. The block takes one request at
// a time; in_stall stays high until the result has been moved to the output
// register, so the next request can enter while a result waits on out_stall.
// A bad or oversized request is answered from the check state without a leaf read.
// An allocate reads leaf words one per cycle from the first, stopping at the
// first word that fits. A free sweeps every leaf word through a
// read-modify-write stream. The single leaf-word read port paces both scans.
// Reset, and every write on the cfg channel (cfg_valid/cfg_ready, data on
// slot_count), starts a clearing pass that writes every leaf word; requests
// are stalled during the pass.
// A stalled output holds its word; the block then waits with the next result.
// ----------------------------------------------------------------------------
module run_bitmap_allocator #(
	parameter int unsigned LEAF_BITS = rba_pkg::LEAF_BITS_DEF,
	parameter int unsigned MAX_SLOTS = rba_pkg::MAX_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic [$clog2(MAX_SLOTS)-1:0]    start_slot,
	input  logic [$clog2(MAX_SLOTS+1)-1:0]  count,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [$clog2(MAX_SLOTS)-1:0]    slot,
	output logic [rba_pkg::ST_W-1:0]        status,
	output logic [$clog2(MAX_SLOTS+1)-1:0]  free_count,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [$clog2(MAX_SLOTS+1)-1:0]  slot_count
);
	import rba_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t st;

	rba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.st        (st),
		.cmd       (cmd)
	);

	rba_dp #(
		.LEAF_BITS (LEAF_BITS),
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg_we     (cfg_valid && cfg_ready),
		.slot_count (slot_count),
		.func       (func),
		.start_slot (start_slot),
		.count      (count),
		.slot       (slot),
		.status     (status),
		.free_count (free_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the run bitmap allocator
// Drives alloc and free requests under random idling and stalls, predicts
// every result word from a behavioral copy of the slot bitmap, and compares
// the words field by field. Several slot counts are written between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import rba_pkg::*;

	localparam int unsigned LEAF_BITS = 32;
	localparam int unsigned MAX_SLOTS = 4096;
	localparam int unsigned LEAF_COUNT = MAX_SLOTS / LEAF_BITS;

	typedef struct packed {
		logic [11:0]     slot;
		logic [ST_W-1:0] status;
		logic [12:0]     free_count;
	} result_t;

	typedef struct {
		logic        fn;
		logic [11:0] start;
		logic [12:0] cnt;
		logic        has_exp;
		result_t     exp;
	} req_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = 1'b0;
	logic [11:0] start_slot = '0;
	logic [12:0] count = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [11:0] slot;
	logic [ST_W-1:0] status;
	logic [12:0] free_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [12:0] slot_count = '0;

	logic [LEAF_BITS-1:0] leaf_map [LEAF_COUNT];
	int unsigned model_free;
	int unsigned map_size;
	result_t expected_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;

	always #5 clk = ~clk;

	run_bitmap_allocator i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .start_slot(start_slot), .count(count),
		.out_valid(out_valid), .out_stall(out_stall),
		.slot(slot), .status(status), .free_count(free_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .slot_count(slot_count)
	);

	function automatic void init_map(input int unsigned value);
		int unsigned base;
		map_size = (value > MAX_SLOTS) ? MAX_SLOTS : value;
		for (int w = 0; w < LEAF_COUNT; w++) begin
			base = w * LEAF_BITS;
			if (base + LEAF_BITS <= map_size)
				leaf_map[w] = '0;
			else if (base >= map_size)
				leaf_map[w] = '1;
			else
				leaf_map[w] = '1 << (map_size - base);
		end
		model_free = map_size;
	endfunction

	function automatic result_t predict_alloc_free(input logic fn, input int unsigned start,
			input int unsigned cnt);
		result_t r;
		logic [LEAF_BITS-1:0] run;
		r = '{slot: '0, status: ST_DONE, free_count: '0};
		if (cnt == 0) begin
			r.status = ST_BAD;
		end else if (fn == FN_ALLOC) begin
			r.status = ST_NOSPACE;
			if (cnt <= LEAF_BITS) begin
				run = {LEAF_BITS{1'b1}} >> (LEAF_BITS - cnt);
				for (int w = 0; w < LEAF_COUNT && r.status != ST_DONE; w++)
					for (int j = 0; j + cnt <= LEAF_BITS; j++)
						if ((leaf_map[w] & (run << j)) == '0) begin
							leaf_map[w] |= run << j;
							model_free = (model_free >= cnt) ? model_free - cnt : 0;
							r.slot = 12'(w * LEAF_BITS + j);
							r.status = ST_DONE;
							break;
						end
			end
		end else if (start + cnt > map_size) begin
			r.status = ST_BAD;
		end else begin
			for (int unsigned s = start; s < start + cnt; s++)
				leaf_map[s / LEAF_BITS][s % LEAF_BITS] = 1'b0;
			model_free += cnt;
			if (model_free > MAX_SLOTS)
				model_free = MAX_SLOTS;
		end
		r.free_count = 13'(model_free);
		return r;
	endfunction

	// Issues one request word; the typed expectation, if given, must match the predictor.
	// Valid stays high after acceptance until the next word or the drain takes it down.
	task automatic send_request(input req_row_t row);
		result_t p;
		p = predict_alloc_free(row.fn, row.start, row.cnt);
		if (row.has_exp && p != row.exp) begin
			$display("%0t: table/predictor disagree: expected %h, actual %h", $time, row.exp, p);
			errors++;
		end
		expected_q.push_back(p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= row.fn;
		start_slot <= row.start;
		count <= row.cnt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic random_request();
		req_row_t row;
		int unsigned k;
		k = $urandom_range(99);
		row.has_exp = 1'b0;
		row.exp = '0;
		row.fn = (k < 55) ? FN_ALLOC : FN_FREE;
		row.start = 12'($urandom_range(4095));
		if (k < 3)
			row.cnt = 13'($urandom_range(8191));
		else if (k < 5)
			row.cnt = 0;
		else if (row.fn == FN_ALLOC)
			row.cnt = ($urandom_range(9) == 0) ? 13'($urandom_range(40, 33)) :
				13'($urandom_range(32, 1));
		else begin
			if (map_size == 0) row.cnt = 13'($urandom_range(8, 1));
			else begin
				row.start = 12'($urandom_range(map_size - 1));
				row.cnt = ($urandom_range(19) == 0) ? 13'($urandom_range(map_size)) :
					13'($urandom_range(64, 1));
				if (row.start + row.cnt > map_size && $urandom_range(3) != 0)
					row.cnt = 13'(map_size - row.start);
				if (row.cnt == 0) row.cnt = 1;
			end
		end
		send_request(row);
	endtask

	task automatic drain_queue();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	task automatic write_slot_count(input logic [12:0] value);
		cfg_valid <= 1'b1;
		slot_count <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		init_map(value);
	endtask

	// Receiver stalls; a long hold-off lets the block fill up and stall its input.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		result_t got, exp;
		if (out_valid && !out_stall) begin
			got = '{slot: slot, status: status, free_count: free_count};
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
			end else begin
				exp = expected_q.pop_front();
				if (got.slot !== exp.slot)
					$display("%0t: slot expected %0d, actual %0d", $time, exp.slot, got.slot);
				if (got.status !== exp.status)
					$display("%0t: status expected %0d, actual %0d", $time, exp.status,
						got.status);
				if (got.free_count !== exp.free_count)
					$display("%0t: free_count expected %0d, actual %0d", $time,
						exp.free_count, got.free_count);
				if (got !== exp) errors++;
			end
		end
	end

	initial begin
		#50000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		req_row_t dir_table[$];
		logic [12:0] sizes[6];
		init_map(MAX_SLOTS);
		dir_table = '{
			'{FN_ALLOC, 12'd0, 13'd0, 1'b1, '{12'd0, ST_BAD, 13'd4096}},
			'{FN_FREE, 12'd0, 13'd0, 1'b1, '{12'd0, ST_BAD, 13'd4096}},
			'{FN_ALLOC, 12'd0, 13'd1, 1'b1, '{12'd0, ST_DONE, 13'd4095}},
			'{FN_ALLOC, 12'd4095, 13'd32, 1'b1, '{12'd32, ST_DONE, 13'd4063}},
			'{FN_ALLOC, 12'd0, 13'd33, 1'b1, '{12'd0, ST_NOSPACE, 13'd4063}},
			'{FN_ALLOC, 12'd0, 13'd4096, 1'b1, '{12'd0, ST_NOSPACE, 13'd4063}},
			'{FN_ALLOC, 12'd0, 13'd8191, 1'b1, '{12'd0, ST_NOSPACE, 13'd4063}},
			'{FN_ALLOC, 12'd0, 13'd31, 1'b1, '{12'd1, ST_DONE, 13'd4032}},
			'{FN_FREE, 12'd4095, 13'd2, 1'b1, '{12'd0, ST_BAD, 13'd4032}},
			'{FN_FREE, 12'd4095, 13'd1, 1'b1, '{12'd0, ST_DONE, 13'd4033}},
			'{FN_FREE, 12'd0, 13'd4096, 1'b1, '{12'd0, ST_DONE, 13'd4096}},
			'{FN_FREE, 12'd0, 13'd8191, 1'b1, '{12'd0, ST_BAD, 13'd4096}},
			'{FN_ALLOC, 12'd0, 13'd17, 1'b0, '0},
			'{FN_ALLOC, 12'd0, 13'd16, 1'b0, '0},
			'{FN_FREE, 12'd5, 13'd40, 1'b0, '0},
			'{FN_ALLOC, 12'd0, 13'd20, 1'b0, '0},
			'{FN_FREE, 12'd2730, 13'd1365, 1'b0, '0}
		};
		sizes = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd100, 13'd2049};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_table[i]) send_request(dir_table[i]);
		drain_queue();
		for (int ph = 0; ph < 9; ph++) begin
			write_slot_count((ph < 6) ? sizes[ph] : 13'($urandom_range(4096, 1)));
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 85; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 85; end
				default: begin send_idle_pct = 18; stall_pct = 18; end
			endcase
			if (ph == 1) hold_cycles <= 1200;
			if (ph == 4) begin send_idle_pct = 0; hold_cycles <= 600; end
			repeat (150) random_request();
			drain_queue();
		end
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
